// ===== hw/rtl/csvrfc_pkg.sv =====
// Shared types and constants for the CSV record field counter.
`default_nettype none

package csvrfc_pkg;

   // Byte codes that steer the parser
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Width of the reported count
   localparam int unsigned FIELD_COUNT_WIDTH = 16;

   // Command carried in req_tuser
   typedef enum logic {
      CMD_DATA = 1'b0,
      CMD_END  = 1'b1
   } command_type;

   // Result status
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNCLOSED  = 2'd1,
      STATUS_JUNK      = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PHASE_START  = 5'b00001,
      PHASE_PLAIN  = 5'b00010,
      PHASE_QUOTED = 5'b00100,
      PHASE_QSEEN  = 5'b01000,
      PHASE_DONE   = 5'b10000
   } phase_type;

   // One finished record, handed from the parser to the result register
   typedef struct packed {
      logic                                valid;
      logic [FIELD_COUNT_WIDTH-1:0]        field_count;
      status_type                          status;
   } result_type;

endpackage : csvrfc_pkg

`default_nettype wire

// ===== hw/rtl/csvrfc_parser.sv =====
// Byte-wise CSV record parser: phase, field counter and first-error state.
`default_nettype none

module csvrfc_parser #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire csvrfc_pkg::command_type  command,
   input  wire logic [7:0]               byte_value,
   output csvrfc_pkg::result_type        result
);

   csvrfc_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   csvrfc_pkg::status_type  error_ff, error_in;

   logic                    is_quote;
   logic                    is_comma;
   logic                    is_sep;
   logic                    counter_full;
   logic                    finish_field;
   csvrfc_pkg::status_type  final_error;
   logic [COUNT_WIDTH-1:0]  final_count;

   // Classify the incoming byte
   assign is_quote     = (byte_value == csvrfc_pkg::CHAR_QUOTE);
   assign is_comma     = (byte_value == csvrfc_pkg::CHAR_COMMA);
   assign is_sep       = is_comma || (byte_value == csvrfc_pkg::CHAR_CR) ||
                         (byte_value == csvrfc_pkg::CHAR_LF);
   assign counter_full = (count_ff == {COUNT_WIDTH{1'b1}});

   // Advance the phase on a data byte, close the record on the end marker
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      finish_field = 1'b0;
      final_error  = error_ff;
      final_count  = count_ff;
      result       = '0;

      if (accept && (command == csvrfc_pkg::CMD_DATA)) begin
         if (error_ff == csvrfc_pkg::STATUS_OK) begin
            unique case (phase_ff)
               csvrfc_pkg::PHASE_START: begin
                  if (is_quote) begin
                     phase_in = csvrfc_pkg::PHASE_QUOTED;
                  end else if (is_sep) begin
                     finish_field = 1'b1;
                  end else begin
                     phase_in = csvrfc_pkg::PHASE_PLAIN;
                  end
               end
               csvrfc_pkg::PHASE_PLAIN: begin
                  finish_field = is_sep;
               end
               csvrfc_pkg::PHASE_QUOTED: begin
                  if (is_quote) begin
                     phase_in = csvrfc_pkg::PHASE_QSEEN;
                  end
               end
               csvrfc_pkg::PHASE_QSEEN: begin
                  if (is_quote) begin
                     phase_in = csvrfc_pkg::PHASE_QUOTED;
                  end else if (is_sep) begin
                     finish_field = 1'b1;
                  end else begin
                     error_in = csvrfc_pkg::STATUS_JUNK;
                     phase_in = csvrfc_pkg::PHASE_DONE;
                  end
               end
               default: begin
                  // record already ended: drop the byte
               end
            endcase

            // Complete the field at a separator
            if (finish_field) begin
               if (counter_full) begin
                  error_in = csvrfc_pkg::STATUS_OVERFLOW;
                  phase_in = csvrfc_pkg::PHASE_DONE;
               end else begin
                  count_in = count_ff + 1'b1;
                  phase_in = is_comma ? csvrfc_pkg::PHASE_START
                                      : csvrfc_pkg::PHASE_DONE;
               end
            end
         end
      end else if (accept) begin
         // End marker: close an open field, then report and start over
         if (error_ff == csvrfc_pkg::STATUS_OK) begin
            unique case (phase_ff)
               csvrfc_pkg::PHASE_QUOTED: begin
                  final_error = csvrfc_pkg::STATUS_UNCLOSED;
               end
               csvrfc_pkg::PHASE_START,
               csvrfc_pkg::PHASE_PLAIN,
               csvrfc_pkg::PHASE_QSEEN: begin
                  if (counter_full) begin
                     final_error = csvrfc_pkg::STATUS_OVERFLOW;
                  end else begin
                     final_count = count_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         result.valid  = 1'b1;
         result.status = final_error;
         if (final_error == csvrfc_pkg::STATUS_OK) begin
            result.field_count = csvrfc_pkg::FIELD_COUNT_WIDTH'(final_count);
         end

         phase_in = csvrfc_pkg::PHASE_START;
         count_in = '0;
         error_in = csvrfc_pkg::STATUS_OK;
      end
   end

   // Hold the parse state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= csvrfc_pkg::PHASE_START;
         count_ff <= '0;
         error_ff <= csvrfc_pkg::STATUS_OK;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

endmodule : csvrfc_parser

`default_nettype wire

// ===== hw/rtl/csvrfc_out_reg.sv =====
// Result register that holds one record summary until the consumer takes it.
`default_nettype none

module csvrfc_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire csvrfc_pkg::result_type  result,
   output logic                         slot_free,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [15:0]                  rsp_tdata,  // [15:0] field_count
   output logic [1:0]                   rsp_tuser   // [1:0] status
);

   logic                                       valid_ff, valid_in;
   logic [csvrfc_pkg::FIELD_COUNT_WIDTH-1:0]   count_ff;
   csvrfc_pkg::status_type                     status_ff;

   // Free when empty or when the held result leaves in this cycle
   assign slot_free = !valid_ff || rsp_tready;

   // Load a new result, or drop the held one once transferred
   always_comb begin
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (result.valid) begin
         count_ff  <= result.field_count;
         status_ff <= result.status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = count_ff;
   assign rsp_tuser  = status_ff;

endmodule : csvrfc_out_reg

`default_nettype wire

// ===== hw/rtl/csv_record_field_counter_unit.sv =====
// Top level of the CSV first-record field counter.
//
//  Channel | Direction | tdata                | tuser                      | tlast
//  req_    | in        | [7:0] byte_value     | [0] command (0 data, 1 end) | -
//  rsp_    | out       | [15:0] field_count   | [1:0] status               | -
//
// One request transfer per cycle; each byte updates the phase and counter
// in the cycle it is taken. The end marker puts its result in the output
// register, visible on rsp_ the cycle after. A result waiting on rsp_tready
// holds req_tready low only if it is not taken in the same cycle.
// Synchronous active-high reset returns the parser to the start of a field
// with a zero count and empties the output register.
`default_nettype none

module csv_record_field_counter_unit #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,  // [7:0] byte_value
   input  wire logic         req_tuser,  // [0] command
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,  // [15:0] field_count
   output logic [1:0]        rsp_tuser   // [1:0] status
);

   logic                    slot_free;
   logic                    req_accept;
   csvrfc_pkg::result_type  result;

   assign req_tready = slot_free;
   assign req_accept = req_tvalid && req_tready;

   // Parse bytes as they are transferred
   csvrfc_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .command    (csvrfc_pkg::command_type'(req_tuser)),
      .byte_value (req_tdata),
      .result     (result)
   );

   // Hold the record summary for the consumer
   csvrfc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : csv_record_field_counter_unit

`default_nettype wire
